FILE: rtl/chr_pkg.sv
package chr_pkg;

  localparam int unsigned RingDepthDef = 1024;
  localparam int unsigned NodeCountDef = 16;

  localparam logic [31:0] FnvBasis = 32'd2166136261;
  localparam logic [31:0] FnvPrime = 32'd16777619;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_KEY    = 2'd1,
    KIND_DEAD   = 2'd2,
    KIND_ALIVE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_WALK_RD,
    S_WALK_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS_WR,
    S_RESULT
  } state_e;

endpackage

FILE: rtl/chr_if.sv
interface chr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] entry_hash;
  logic [3:0]  node_sel;
  logic [7:0]  key_byte;
  logic        last_byte;
  modport source (output valid, kind, entry_hash, node_sel, key_byte, last_byte,
                  input ready);
  modport sink (input valid, kind, entry_hash, node_sel, key_byte, last_byte,
                output ready);
endinterface

interface chr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  owner_node;
  logic [31:0] key_hash;
  modport source (output valid, status, owner_node, key_hash, input ready);
  modport sink (input valid, status, owner_node, key_hash, output ready);
endinterface

FILE: rtl/chr_ram.sv
module chr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/consistent_hash_ring_lookup_core.sv
// Mark items update the alive mask; a non-last key byte folds into the running hash. A last
// byte finishes the hash, binary-searches the ring for the first entry >= the hash, then walks
// up to the first entry whose owner is alive, wrapping once to the start, else status NONE.
// Insert: binary search, move later entries up one slot, write the entry; full ring gives FULL.
// One transaction in flight; ready stays low while the sequencer runs or a result waits.
// Reset (async, active low): empty ring, all nodes alive, hash at offset basis.
module consistent_hash_ring_lookup_core #(
  parameter int unsigned RingDepth = chr_pkg::RingDepthDef,
  parameter int unsigned NodeCount = chr_pkg::NodeCountDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  chr_in_if.sink    in_if,
  chr_out_if.source out_if
);
  import chr_pkg::*;

  localparam int unsigned AW = $clog2(RingDepth);
  localparam int unsigned FW = $clog2(RingDepth + 1);
  localparam int unsigned NW = (NodeCount > 16) ? 4 : $clog2(NodeCount);

  state_e state_q, state_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [FW-1:0] lo_q, lo_d, hi_q, hi_d;   // search range [lo, hi)
  logic [FW-1:0] ptr_q, ptr_d;
  logic          wrap_q, wrap_d;
  logic [NodeCount-1:0] alive_q, alive_d;
  logic [31:0] run_q, run_d;
  logic [31:0] x_q, x_d;     // hash operand, then key hash; entry hash on insert
  logic        last_q, last_d;
  logic [1:0]  kind_q, kind_d;
  logic [31:0] eh_q, eh_d;
  logic [3:0]  sel_q, sel_d;
  logic        ovld_q, ovld_d;
  logic [1:0]  ost_q, ost_d;
  logic [3:0]  oown_q, oown_d;
  logic [31:0] okh_q, okh_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [35:0]   wdata, rdata;
  logic [FW-1:0] mid;
  logic [31:0]   rh;
  logic [3:0]    ro;
  logic          ralive;

  chr_ram #(.Width(36), .Depth(RingDepth)) u_ram (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign rh = rdata[31:0];
  assign ro = rdata[35:32];
  assign mid = FW'((({1'b0, lo_q} + {1'b0, hi_q}) >> 1));
  always_comb begin
    ralive = 1'b0;
    if ({28'd0, ro} < 32'(NodeCount)) ralive = alive_q[ro[NW-1:0]];
  end

  assign in_if.ready = (state_q == S_IDLE) && !ovld_q;
  assign out_if.valid = ovld_q;
  assign out_if.status = ost_q;
  assign out_if.owner_node = oown_q;
  assign out_if.key_hash = okh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      alive_q <= '1;
      run_q   <= FnvBasis;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      alive_q <= alive_d;
      run_q   <= run_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d; hi_q <= hi_d; ptr_q <= ptr_d; wrap_q <= wrap_d;
    x_q <= x_d; last_q <= last_d; kind_q <= kind_d; eh_q <= eh_d; sel_q <= sel_d;
    ost_q <= ost_d; oown_q <= oown_d; okh_q <= okh_d;
  end

  always_comb begin
    state_d = state_q; fill_d = fill_q; alive_d = alive_q; run_d = run_q;
    lo_d = lo_q; hi_d = hi_q; ptr_d = ptr_q; wrap_d = wrap_q; x_d = x_q;
    last_d = last_q; kind_d = kind_q; eh_d = eh_q; sel_d = sel_q;
    ovld_d = ovld_q; ost_d = ost_q; oown_d = oown_q; okh_d = okh_q;
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    if (out_if.valid && out_if.ready) ovld_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_if.valid && in_if.ready) begin
          kind_d = in_if.kind; eh_d = in_if.entry_hash; sel_d = in_if.node_sel;
          last_d = in_if.last_byte;
          x_d = run_q ^ {24'd0, in_if.key_byte};
          case (kind_e'(in_if.kind))
            KIND_INSERT: begin
              if (fill_q == FW'(RingDepth)) begin
                ost_d = ST_FULL; oown_d = '0; okh_d = '0; state_d = S_RESULT;
              end else begin
                lo_d = '0; hi_d = fill_q; x_d = in_if.entry_hash;
                state_d = S_SRCH_RD;
              end
            end
            KIND_KEY: state_d = S_MUL;
            KIND_DEAD, KIND_ALIVE: begin
              if ({28'd0, in_if.node_sel} < 32'(NodeCount))
                alive_d[in_if.node_sel[NW-1:0]] = (in_if.kind == KIND_ALIVE);
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        x_d = x_q * FnvPrime;
        if (!last_q) begin
          run_d = x_q * FnvPrime; state_d = S_IDLE;
        end else begin
          run_d = FnvBasis; lo_d = '0; hi_d = fill_q; state_d = S_SRCH_RD;
        end
      end
      // Insert finds first entry > hash; lookup finds first entry >= hash.
      S_SRCH_RD: begin
        if (lo_q == hi_q) begin
          ptr_d = lo_q; wrap_d = 1'b0;
          if (kind_q == KIND_INSERT) begin
            ptr_d = fill_q; state_d = S_SHIFT_RD;
          end else state_d = S_WALK_RD;
        end else begin
          raddr = mid[AW-1:0]; state_d = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if ((kind_q == KIND_INSERT) ? (rh <= x_q) : (rh < x_q)) lo_d = mid + 1'b1;
        else hi_d = mid;
        state_d = S_SRCH_RD;
      end
      S_WALK_RD: begin
        if (ptr_q == fill_q) begin
          if (wrap_q || fill_q == '0) begin
            ost_d = ST_NONE; oown_d = '0; okh_d = x_q; state_d = S_RESULT;
          end else begin
            wrap_d = 1'b1; ptr_d = '0;
          end
        end else begin
          raddr = ptr_q[AW-1:0]; state_d = S_WALK_CMP;
        end
      end
      S_WALK_CMP: begin
        if (ralive) begin
          ost_d = ST_OK; oown_d = ro; okh_d = x_q; state_d = S_RESULT;
        end else begin
          ptr_d = ptr_q + 1'b1; state_d = S_WALK_RD;
        end
      end
      // Move entries up one slot from the top down to the insert point.
      S_SHIFT_RD: begin
        if (ptr_q == lo_q) state_d = S_INS_WR;
        else begin
          raddr = AW'(ptr_q - 1'b1); state_d = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        we = 1'b1; waddr = ptr_q[AW-1:0]; wdata = rdata;
        ptr_d = ptr_q - 1'b1; state_d = S_SHIFT_RD;
      end
      S_INS_WR: begin
        we = 1'b1; waddr = lo_q[AW-1:0]; wdata = {sel_q, eh_q};
        fill_d = fill_q + 1'b1;
        ost_d = ST_OK; oown_d = '0; okh_d = '0; state_d = S_RESULT;
      end
      S_RESULT: begin
        ovld_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(RingDepth)) else $error("fill overflow");
  a_ins_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INS_WR |=> fill_q == $past(fill_q) + 1'b1) else $error("insert fill");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q |-> !in_if.ready) else $error("ready with pending result");
  a_srch_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SRCH_CMP |-> lo_q < hi_q) else $error("search range");
endmodule

FILE: tb/sv/tb_consistent_hash_ring_lookup_core.sv
module tb_consistent_hash_ring_lookup_core;
  timeunit 1ns;
  timeprecision 1ps;
  import chr_pkg::*;

  localparam int unsigned RingSlots   = RingDepthDef;
  localparam int unsigned NodeSlots   = NodeCountDef;
  localparam int unsigned CycleLimit  = 6_000_000;
  localparam int unsigned DrainPause  = 40;
  localparam int unsigned HoldCycles  = 400;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] entry_hash;
    logic [3:0]  node_sel;
    logic [7:0]  key_byte;
    logic        last_byte;
  } ring_item_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  owner_node;
    logic [31:0] key_hash;
  } lookup_res_t;

  logic clk;
  logic rst_n;

  chr_in_if  in_if();
  chr_out_if out_if();

  consistent_hash_ring_lookup_core u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  ring_item_t  pending_items[$];
  lookup_res_t owed_results[$];
  ring_item_t  cur_item;

  logic [31:0] mdl_hashes [RingSlots];
  logic [3:0]  mdl_owners [RingSlots];
  int unsigned mdl_fill;
  logic        mdl_alive  [NodeSlots];
  logic [31:0] mdl_run_hash;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        hold_rx;
  logic        pressure_go;
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned inserts_queued;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic ring_item_t mk_item(kind_e k, logic [31:0] h, logic [3:0] sel,
                                         logic [7:0] b, logic last);
    ring_item_t it;
    it.kind       = k;
    it.entry_hash = h;
    it.node_sel   = sel;
    it.key_byte   = b;
    it.last_byte  = last;
    return it;
  endfunction

  // Unused fields carry random values so every bit toggles on every item kind.
  function automatic ring_item_t rand_item(kind_e k);
    return mk_item(k, $urandom(), 4'($urandom_range(15)), 8'($urandom_range(255)),
                   1'($urandom_range(1)));
  endfunction

  function automatic logic node_is_alive(logic [3:0] owner);
    if (owner >= NodeSlots) return 1'b0;
    return mdl_alive[owner];
  endfunction

  task automatic model_ring(ring_item_t it);
    lookup_res_t r;
    logic [31:0] h;
    int unsigned pos;
    logic        found;
    r = '0;
    case (it.kind)
      KIND_INSERT: begin
        if (mdl_fill >= RingSlots) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < mdl_fill && mdl_hashes[pos] <= it.entry_hash) pos++;
          for (int unsigned k = mdl_fill; k > pos; k--) begin
            mdl_hashes[k] = mdl_hashes[k-1];
            mdl_owners[k] = mdl_owners[k-1];
          end
          mdl_hashes[pos] = it.entry_hash;
          mdl_owners[pos] = it.node_sel;
          mdl_fill++;
          r.status = ST_OK;
        end
        owed_results.push_back(r);
      end
      KIND_KEY: begin
        h = (mdl_run_hash ^ {24'd0, it.key_byte}) * FnvPrime;
        if (!it.last_byte) begin
          mdl_run_hash = h;
        end else begin
          mdl_run_hash = FnvBasis;
          found = 1'b0;
          for (int unsigned i = 0; i < mdl_fill && !found; i++) begin
            if (mdl_hashes[i] >= h && node_is_alive(mdl_owners[i])) begin
              found = 1'b1;
              r.owner_node = mdl_owners[i];
            end
          end
          // wrap to the lowest alive entry
          for (int unsigned i = 0; i < mdl_fill && !found; i++) begin
            if (node_is_alive(mdl_owners[i])) begin
              found = 1'b1;
              r.owner_node = mdl_owners[i];
            end
          end
          r.status   = found ? ST_OK : ST_NONE;
          r.key_hash = h;
          owed_results.push_back(r);
        end
      end
      default: begin
        if (it.node_sel < NodeSlots) mdl_alive[it.node_sel] = (it.kind == KIND_ALIVE);
      end
    endcase
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_if.valid      <= 1'b0;
      in_if.kind       <= KIND_INSERT;
      in_if.entry_hash <= '0;
      in_if.node_sel   <= '0;
      in_if.key_byte   <= '0;
      in_if.last_byte  <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) model_ring(cur_item);
      if (!in_if.valid || in_if.ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item          = pending_items.pop_front();
          in_if.valid      <= 1'b1;
          in_if.kind       <= cur_item.kind;
          in_if.entry_hash <= cur_item.entry_hash;
          in_if.node_sel   <= cur_item.node_sel;
          in_if.key_byte   <= cur_item.key_byte;
          in_if.last_byte  <= cur_item.last_byte;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    lookup_res_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (owed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transaction: status %0d owner %0d hash %h",
                     out_if.status, out_if.owner_node, out_if.key_hash);
        end else begin
          want = owed_results.pop_front();
          if (out_if.status !== want.status || out_if.owner_node !== want.owner_node ||
              out_if.key_hash !== want.key_hash) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected status %0d owner %0d hash %h, got %0d %0d %h",
                       want.status, want.owner_node, want.key_hash,
                       out_if.status, out_if.owner_node, out_if.key_hash);
          end
        end
      end
      out_if.ready <= !hold_rx && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("consistent_hash_ring_lookup_core verification failed");
      $finish;
    end
  end

  initial begin
    @(posedge pressure_go);
    @(negedge clk);
    hold_rx = 1'b1;
    for (int c = 0; c < HoldCycles; c++) @(negedge clk);
    hold_rx = 1'b0;
  end

  task automatic wait_drain();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_if.valid || owed_results.size() != 0);
    repeat (DrainPause) @(negedge clk);
  endtask

  task automatic push_key(int unsigned len, logic mix);
    for (int unsigned b = 0; b < len; b++) begin
      pending_items.push_back(mk_item(KIND_KEY, $urandom(), 4'($urandom_range(15)),
                                      8'($urandom_range(255)), b == len - 1));
      // interleave an unrelated transaction inside the key
      if (mix && b != len - 1 && $urandom_range(9) == 0)
        pending_items.push_back(rand_item(kind_e'($urandom_range(3) == 0 ?
                                                  KIND_INSERT : KIND_ALIVE)));
    end
  endtask

  task automatic push_random(int unsigned n);
    int unsigned r;
    int unsigned start;
    start = pending_items.size();
    while (pending_items.size() - start < n) begin
      r = $urandom_range(99);
      if (r < 60) begin
        push_key($urandom_range(1, 6), 1'b1);
      end else if (r < 78 && inserts_queued < 250) begin
        pending_items.push_back(rand_item(KIND_INSERT));
        inserts_queued++;
      end else if (r < 86) begin
        pending_items.push_back(rand_item(KIND_DEAD));
      end else if (r < 96) begin
        pending_items.push_back(rand_item(KIND_ALIVE));
      end else begin
        // noise: a lone non-final byte, later absorbed into the next key
        pending_items.push_back(mk_item(KIND_KEY, $urandom(), 4'($urandom_range(15)),
                                        8'($urandom_range(255)), 1'b0));
      end
    end
  endtask

  initial begin
    int unsigned idle_tab [4];
    int unsigned stall_tab [4];
    idle_tab  = '{0, 71, 0, 22};
    stall_tab = '{0, 0, 71, 22};
    rst_n          = 1'b0;
    hold_rx        = 1'b0;
    pressure_go    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatches     = 0;
    cycles         = 0;
    inserts_queued = 0;
    mdl_fill       = 0;
    mdl_run_hash   = FnvBasis;
    for (int i = 0; i < NodeSlots; i++) mdl_alive[i] = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty ring, extreme hashes, ties, dead owners and wrap-around
    pending_items.push_back(mk_item(KIND_KEY, 32'hFFFF_FFFF, 4'hF, 8'h00, 1'b1));
    pending_items.push_back(mk_item(KIND_INSERT, 32'h0000_0000, 4'h0, 8'hFF, 1'b1));
    pending_items.push_back(mk_item(KIND_INSERT, 32'hFFFF_FFFF, 4'hF, 8'h00, 1'b0));
    pending_items.push_back(mk_item(KIND_INSERT, 32'h8000_0000, 4'h5, 8'hAA, 1'b0));
    pending_items.push_back(mk_item(KIND_INSERT, 32'h8000_0000, 4'h9, 8'h55, 1'b1));
    pending_items.push_back(mk_item(KIND_KEY, 32'h0, 4'h0, 8'h61, 1'b1));
    pending_items.push_back(mk_item(KIND_KEY, 32'h0, 4'h0, 8'hFF, 1'b0));
    pending_items.push_back(mk_item(KIND_DEAD, 32'h1234_5678, 4'h5, 8'h00, 1'b0));
    pending_items.push_back(mk_item(KIND_KEY, 32'h0, 4'h0, 8'h00, 1'b0));
    pending_items.push_back(mk_item(KIND_KEY, 32'h0, 4'h0, 8'hFF, 1'b1));
    pending_items.push_back(mk_item(KIND_DEAD, 32'h0, 4'h9, 8'h00, 1'b0));
    pending_items.push_back(mk_item(KIND_DEAD, 32'h0, 4'h0, 8'h00, 1'b0));
    pending_items.push_back(mk_item(KIND_KEY, 32'h0, 4'h0, 8'h7F, 1'b1));
    pending_items.push_back(mk_item(KIND_DEAD, 32'h0, 4'hF, 8'h00, 1'b0));
    pending_items.push_back(mk_item(KIND_KEY, 32'h0, 4'h0, 8'h80, 1'b1));
    pending_items.push_back(mk_item(KIND_ALIVE, 32'h0, 4'h0, 8'h00, 1'b0));
    pending_items.push_back(mk_item(KIND_ALIVE, 32'h0, 4'h5, 8'h00, 1'b0));
    pending_items.push_back(mk_item(KIND_ALIVE, 32'h0, 4'h9, 8'h00, 1'b0));
    pending_items.push_back(mk_item(KIND_ALIVE, 32'h0, 4'hF, 8'h00, 1'b0));
    pending_items.push_back(mk_item(KIND_KEY, 32'h0, 4'h0, 8'h01, 1'b1));
    wait_drain();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_tab[p];
      recv_stall_pct = stall_tab[p];
      push_random(80);
      if (p == 0) pressure_go = 1'b1;
      wait_drain();
    end

    // fill the ring to capacity and past it at the top end so no entries need moving
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (mdl_fill + pending_items.size() < RingSlots + 3)
      pending_items.push_back(mk_item(KIND_INSERT, 32'hFFFF_FFFF, 4'($urandom_range(15)),
                                      8'($urandom_range(255)), 1'($urandom_range(1))));
    for (int k = 0; k < 4; k++) push_key($urandom_range(1, 4), 1'b0);
    pending_items.push_back(rand_item(KIND_DEAD));
    for (int k = 0; k < 3; k++) push_key($urandom_range(1, 4), 1'b0);
    for (int n = 0; n < NodeSlots; n++)
      pending_items.push_back(mk_item(KIND_ALIVE, $urandom(), 4'(n), 8'h00, 1'b0));
    wait_drain();

    if (mismatches == 0) begin
      $display("consistent_hash_ring_lookup_core verification clean");
    end else begin
      $display("consistent_hash_ring_lookup_core verification failed");
    end
    $finish;
  end

endmodule
